[design/chess_attack_bitboard_generator_top_assert.svh]
// Assertion macros for the attack bitboard generator, compiled out under SYNTH.
`ifndef CHESS_ATTACK_BITBOARD_GENERATOR_TOP_ASSERT_SVH
`define CHESS_ATTACK_BITBOARD_GENERATOR_TOP_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk, off during reset.
`define CABG_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cabg assertion failed");
// Next-cycle implication, sampled on clk, off during reset.
`define CABG_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cabg assertion failed");
`else
`define CABG_ASSERT_IMP(lbl, ante, cons)
`define CABG_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[design/cabg_pkg.sv]
// Shared types, piece codes and move offset tables for the attack generator.
package cabg_pkg;

	typedef enum logic [2:0] {
		PIECE_ROOK   = 3'd0,
		PIECE_BISHOP = 3'd1,
		PIECE_KNIGHT = 3'd2,
		PIECE_KING   = 3'd3,
		PIECE_WPAWN  = 3'd4,
		PIECE_BPAWN  = 3'd5
	} piece_t;

	typedef logic signed [2:0] off_t;
	typedef logic [63:0] board_t;

	localparam off_t ROOK_DF [4] = '{3'sd0, 3'sd0, -3'sd1, 3'sd1};
	localparam off_t ROOK_DR [4] = '{3'sd1, -3'sd1, 3'sd0, 3'sd0};
	localparam off_t BISHOP_DF [4] = '{-3'sd1, 3'sd1, -3'sd1, 3'sd1};
	localparam off_t BISHOP_DR [4] = '{3'sd1, 3'sd1, -3'sd1, -3'sd1};
	localparam off_t KNIGHT_DF [8] = '{-3'sd1, 3'sd1, -3'sd1, 3'sd1,
		-3'sd2, -3'sd2, 3'sd2, 3'sd2};
	localparam off_t KNIGHT_DR [8] = '{3'sd2, 3'sd2, -3'sd2, -3'sd2,
		-3'sd1, 3'sd1, -3'sd1, 3'sd1};
	localparam off_t KING_DF [8] = '{3'sd0, 3'sd0, -3'sd1, 3'sd1,
		-3'sd1, 3'sd1, -3'sd1, 3'sd1};
	localparam off_t KING_DR [8] = '{3'sd1, -3'sd1, 3'sd0, 3'sd0,
		3'sd1, 3'sd1, -3'sd1, -3'sd1};
	localparam off_t PAWN_DF [2] = '{-3'sd1, 3'sd1};

	// Single target bit for a leap, zero when it falls off the board.
	function automatic board_t leap_bit(logic [2:0] f, logic [2:0] r, off_t df, off_t dr);
		logic [4:0] nf;
		logic [4:0] nr;
		board_t b;
		nf = {2'b00, f} + {{2{df[2]}}, df};
		nr = {2'b00, r} + {{2{dr[2]}}, dr};
		b = '0;
		if (nf[4:3] == 2'b00 && nr[4:3] == 2'b00) begin
			b[{nr[2:0], nf[2:0]}] = 1'b1;
		end
		return b;
	endfunction

	// Walk one ray to the edge, keep the first blocker, stop after it.
	function automatic board_t ray(logic [2:0] f, logic [2:0] r, board_t occ,
		off_t df, off_t dr);
		logic [4:0] cf;
		logic [4:0] cr;
		logic [5:0] idx;
		logic open;
		board_t acc;
		cf = {2'b00, f};
		cr = {2'b00, r};
		open = 1'b1;
		acc = '0;
		for (int i = 0; i < 7; i++) begin
			cf = cf + {{2{df[2]}}, df};
			cr = cr + {{2{dr[2]}}, dr};
			if (open && cf[4:3] == 2'b00 && cr[4:3] == 2'b00) begin
				idx = {cr[2:0], cf[2:0]};
				acc[idx] = 1'b1;
				if (occ[idx]) begin
					open = 1'b0;
				end
			end else begin
				open = 1'b0;
			end
		end
		return acc;
	endfunction

endpackage

[design/chess_attack_bitboard_generator_top.sv]
// Top level of the chess attack bitboard generator: input stage, attack logic, result stage.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------
//  in      | request   | in_valid / in_stall   | cmd, square, occupancy
//  out     | result    | out_valid / out_stall | attack_set
//
// One request enters per cycle while in_stall is low. Its result passes from the
// input register through the attack logic into the result register, which
// drives out. The seven-step ray walk sits between the two registers.
// Reset clears only the two valid flags; payload registers are not reset.
// A stall on out holds the result register, and in_stall rises once the input
// register is full behind it. Up to two requests are held while out stalls.
// Piece codes six and seven give an empty attack set.
`include "chess_attack_bitboard_generator_top_assert.svh"

module chess_attack_bitboard_generator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [5:0]  square,
	input  logic [63:0] occupancy,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] attack_set
);

	logic        valid_s1;
	logic [2:0]  cmd_s1;
	logic [5:0]  square_s1;
	logic [63:0] occ_s1;
	logic        valid_s2;
	logic [63:0] attack_s2;
	logic [63:0] attack_d;
	logic        adv_s1;
	logic        adv_s2;

	// Advance the result stage whenever it is empty or being taken.
	assign adv_s2 = !valid_s2 || !out_stall;
	// Advance the input stage when it is empty or can drain into the result stage.
	assign adv_s1 = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	// Capture the request payload only when a new request is taken.
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			cmd_s1 <= cmd;
			square_s1 <= square;
			occ_s1 <= occupancy;
		end
	end

	cabg_attack u_attack (
		.cmd        (cmd_s1),
		.square     (square_s1),
		.occupancy  (occ_s1),
		.attack_set (attack_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// Load the result register from the input stage; hold it under stall.
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			attack_s2 <= attack_d;
		end
	end

	assign out_valid = valid_s2;
	assign attack_set = attack_s2;

	// An accepted request lands in the input stage on the next edge.
	`CABG_ASSERT_NXT(a_accept_fills_s1, in_valid && !in_stall, valid_s1)
	// A full input stage behind a stalled result must push back on in.
	`CABG_ASSERT_IMP(a_backpressure, valid_s1 && valid_s2 && out_stall, in_stall)
	// A piece never attacks its own origin square.
	`CABG_ASSERT_IMP(a_origin_clear, valid_s1, !attack_d[square_s1])
	// A pawn attacks at most two squares.
	`CABG_ASSERT_IMP(a_pawn_two,
		valid_s1 && (cmd_s1 == cabg_pkg::PIECE_WPAWN || cmd_s1 == cabg_pkg::PIECE_BPAWN),
		$countones(attack_d) <= 2)

endmodule

[design/cabg_attack.sv]
// Combinational attack set for one piece kind, origin square and blocker board.
module cabg_attack (
	input  logic [2:0]  cmd,
	input  logic [5:0]  square,
	input  logic [63:0] occupancy,
	output logic [63:0] attack_set
);

	logic [2:0] file_w;
	logic [2:0] rank_w;
	cabg_pkg::board_t rook_w;
	cabg_pkg::board_t bishop_w;
	cabg_pkg::board_t knight_w;
	cabg_pkg::board_t king_w;
	cabg_pkg::board_t wpawn_w;
	cabg_pkg::board_t bpawn_w;

	assign file_w = square[2:0];
	assign rank_w = square[5:3];

	// Eight rays run side by side, each at most seven short steps.
	always_comb begin
		rook_w = '0;
		bishop_w = '0;
		for (int d = 0; d < 4; d++) begin
			rook_w = rook_w | cabg_pkg::ray(file_w, rank_w, occupancy,
				cabg_pkg::ROOK_DF[d], cabg_pkg::ROOK_DR[d]);
			bishop_w = bishop_w | cabg_pkg::ray(file_w, rank_w, occupancy,
				cabg_pkg::BISHOP_DF[d], cabg_pkg::BISHOP_DR[d]);
		end
	end

	always_comb begin
		knight_w = '0;
		king_w = '0;
		for (int i = 0; i < 8; i++) begin
			knight_w = knight_w | cabg_pkg::leap_bit(file_w, rank_w,
				cabg_pkg::KNIGHT_DF[i], cabg_pkg::KNIGHT_DR[i]);
			king_w = king_w | cabg_pkg::leap_bit(file_w, rank_w,
				cabg_pkg::KING_DF[i], cabg_pkg::KING_DR[i]);
		end
	end

	always_comb begin
		wpawn_w = '0;
		bpawn_w = '0;
		for (int i = 0; i < 2; i++) begin
			wpawn_w = wpawn_w | cabg_pkg::leap_bit(file_w, rank_w,
				cabg_pkg::PAWN_DF[i], 3'sd1);
			bpawn_w = bpawn_w | cabg_pkg::leap_bit(file_w, rank_w,
				cabg_pkg::PAWN_DF[i], -3'sd1);
		end
	end

	always_comb begin
		case (cmd)
			cabg_pkg::PIECE_ROOK:   attack_set = rook_w;
			cabg_pkg::PIECE_BISHOP: attack_set = bishop_w;
			cabg_pkg::PIECE_KNIGHT: attack_set = knight_w;
			cabg_pkg::PIECE_KING:   attack_set = king_w;
			cabg_pkg::PIECE_WPAWN:  attack_set = wpawn_w;
			cabg_pkg::PIECE_BPAWN:  attack_set = bpawn_w;
			default:                attack_set = '0;
		endcase
	end

endmodule

[bench/chess_attack_bitboard_generator_top_tb.sv]
// Self-checking testbench for the chess attack bitboard generator top level.
module chess_attack_bitboard_generator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Piece codes past the black pawn; the block must answer them with an empty board.
	localparam logic [2:0] PIECE_SPARE_A = 3'd6;
	localparam logic [2:0] PIECE_SPARE_B = 3'd7;

	// Generous bound on the whole run: about 2000 requests, each at worst a few
	// sender gaps plus a few receiver stalls, then taken many times over.
	localparam int unsigned CYCLE_LIMIT = 400000;
	// Cycles to linger once the result queue is empty: two pipeline registers and margin.
	localparam int DRAIN_CYCLES = 12;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  cmd = '0;
	logic [5:0]  square = '0;
	logic [63:0] occupancy = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] attack_set;

	// Attack sets predicted for accepted requests, oldest first.
	cabg_pkg::board_t pending_attacks[$];
	int          fail_count = 0;
	int unsigned cycle_count = 0;
	// Chance in a hundred that the sender holds off a cycle, or the receiver stalls.
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;

	chess_attack_bitboard_generator_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.square    (square),
		.occupancy (occupancy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.attack_set(attack_set)
	);

	always #5 clk = ~clk;

	// Compute the attacked squares for one request. Sliders walk each ray until
	// the edge, keeping the first blocker; leapers take each offset once and drop
	// anything that leaves the board. The origin's own occupancy bit never matters
	// because rays start one step away from it.
	function automatic cabg_pkg::board_t predict_attacks(input logic [2:0] kind,
		input logic [5:0] sq, input cabg_pkg::board_t occ);
		int     f0;
		int     r0;
		int     f;
		int     r;
		int     i;
		int     dir_count;
		int     df[8];
		int     dr[8];
		bit     sliding;
		cabg_pkg::board_t attacked;
		f0 = int'(sq[2:0]);
		r0 = int'(sq[5:3]);
		attacked = '0;
		sliding = 1'b0;
		dir_count = 0;
		df = '{default: 0};
		dr = '{default: 0};
		case (kind)
			cabg_pkg::PIECE_ROOK: begin
				df = '{0, 0, -1, 1, 0, 0, 0, 0};
				dr = '{1, -1, 0, 0, 0, 0, 0, 0};
				dir_count = 4;
				sliding = 1'b1;
			end
			cabg_pkg::PIECE_BISHOP: begin
				df = '{-1, 1, -1, 1, 0, 0, 0, 0};
				dr = '{1, 1, -1, -1, 0, 0, 0, 0};
				dir_count = 4;
				sliding = 1'b1;
			end
			cabg_pkg::PIECE_KNIGHT: begin
				df = '{-1, 1, -1, 1, -2, -2, 2, 2};
				dr = '{2, 2, -2, -2, -1, 1, -1, 1};
				dir_count = 8;
			end
			cabg_pkg::PIECE_KING: begin
				df = '{0, 0, -1, 1, -1, 1, -1, 1};
				dr = '{1, -1, 0, 0, 1, 1, -1, -1};
				dir_count = 8;
			end
			cabg_pkg::PIECE_WPAWN: begin
				df = '{-1, 1, 0, 0, 0, 0, 0, 0};
				dr = '{1, 1, 0, 0, 0, 0, 0, 0};
				dir_count = 2;
			end
			cabg_pkg::PIECE_BPAWN: begin
				df = '{-1, 1, 0, 0, 0, 0, 0, 0};
				dr = '{-1, -1, 0, 0, 0, 0, 0, 0};
				dir_count = 2;
			end
			default: begin
				dir_count = 0;
			end
		endcase
		for (i = 0; i < dir_count; i++) begin
			f = f0 + df[i];
			r = r0 + dr[i];
			while (f >= 0 && f < 8 && r >= 0 && r < 8) begin
				attacked[r * 8 + f] = 1'b1;
				// Leapers stop after one step; sliders stop on the first blocker.
				if (!sliding || occ[r * 8 + f])
					break;
				f += df[i];
				r += dr[i];
			end
		end
		return attacked;
	endfunction

	// Board generator biased toward shapes that make rays interesting: sparse
	// boards let rays run far, dense ones cut them short, and the two extremes
	// are kept in the mix.
	function automatic cabg_pkg::board_t random_board();
		cabg_pkg::board_t b;
		case ($urandom_range(5))
			0: b = {$urandom, $urandom};
			1: b = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
			2: b = (64'd1 << $urandom_range(63)) | (64'd1 << $urandom_range(63));
			3: b = {$urandom, $urandom} | {$urandom, $urandom};
			4: b = {$urandom, $urandom} & {$urandom, $urandom};
			default: b = $urandom_range(1) ? '1 : '0;
		endcase
		return b;
	endfunction

	// Random piece code: mostly real pieces, now and then a spare code.
	function automatic logic [2:0] random_piece();
		if ($urandom_range(15) == 0)
			return $urandom_range(1) ? PIECE_SPARE_A : PIECE_SPARE_B;
		return 3'($urandom_range(5));
	endfunction

	// Offer one request and hold it until accepted. Idle cycles before it carry
	// junk payload with valid low. Valid stays high on return so back-to-back
	// requests need no extra cycle; call sites lower it themselves.
	task automatic send_request(input logic [2:0] kind, input logic [5:0] sq,
		input cabg_pkg::board_t occ);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			cmd <= 3'($urandom);
			square <= 6'($urandom);
			occupancy <= {$urandom, $urandom};
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= kind;
		square <= sq;
		occupancy <= occ;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Drop valid and wait until every predicted result has come back.
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_attacks.size() != 0)
			@(posedge clk);
	endtask

	// Rook and bishop from the corners and the middle: empty board, full board,
	// a board holding only the origin (the origin bit must be ignored), random board.
	task automatic test_sliders();
		send_request(cabg_pkg::PIECE_ROOK, 6'd0, 64'd0);
		send_request(cabg_pkg::PIECE_ROOK, 6'd63, '1);
		send_request(cabg_pkg::PIECE_ROOK, 6'd27, 64'd1 << 27);
		send_request(cabg_pkg::PIECE_ROOK, 6'd36, random_board());
		send_request(cabg_pkg::PIECE_BISHOP, 6'd0, 64'd0);
		send_request(cabg_pkg::PIECE_BISHOP, 6'd7, '1);
		send_request(cabg_pkg::PIECE_BISHOP, 6'd56, 64'd0);
		send_request(cabg_pkg::PIECE_BISHOP, 6'd35, 64'd1 << 35);
		send_request(cabg_pkg::PIECE_BISHOP, 6'd63, random_board());
	endtask

	// Knight and king at corners, an edge and the center; full boards show that
	// occupancy has no effect on leapers.
	task automatic test_leapers();
		send_request(cabg_pkg::PIECE_KNIGHT, 6'd0, '1);
		send_request(cabg_pkg::PIECE_KNIGHT, 6'd63, 64'd0);
		send_request(cabg_pkg::PIECE_KNIGHT, 6'd28, random_board());
		send_request(cabg_pkg::PIECE_KNIGHT, 6'd15, '1);
		send_request(cabg_pkg::PIECE_KING, 6'd0, 64'd0);
		send_request(cabg_pkg::PIECE_KING, 6'd63, '1);
		send_request(cabg_pkg::PIECE_KING, 6'd36, random_board());
	endtask

	// Pawns on the rank past which they have no targets, and on both file edges.
	task automatic test_pawns();
		send_request(cabg_pkg::PIECE_WPAWN, 6'd56, '1);
		send_request(cabg_pkg::PIECE_WPAWN, 6'd63, 64'd0);
		send_request(cabg_pkg::PIECE_WPAWN, 6'd8, random_board());
		send_request(cabg_pkg::PIECE_WPAWN, 6'd15, '1);
		send_request(cabg_pkg::PIECE_BPAWN, 6'd0, '1);
		send_request(cabg_pkg::PIECE_BPAWN, 6'd7, 64'd0);
		send_request(cabg_pkg::PIECE_BPAWN, 6'd55, random_board());
	endtask

	// Spare piece codes must give an empty set whatever the board.
	task automatic test_spare_codes();
		send_request(PIECE_SPARE_A, 6'd27, '1);
		send_request(PIECE_SPARE_B, 6'd0, random_board());
	endtask

	// Random traffic at the current idle and stall rates.
	task automatic test_random_traffic(input int count);
		repeat (count)
			send_request(random_piece(), 6'($urandom_range(63)), random_board());
	endtask

	// Push a burst, then hold the sender off until the pipeline has emptied,
	// and resume from a cold start.
	task automatic test_drain_pause();
		test_random_traffic(30);
		wait_results_drained();
		test_random_traffic(30);
	endtask

	// Receiver: stall at the current rate, redrawn every cycle.
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	// Scoreboard: predict at each accepted request, compare at each accepted
	// result. Predict before comparing so ordering within one edge cannot matter.
	always @(posedge clk) begin
		cabg_pkg::board_t expected_set;
		if (arst_n) begin
			if (in_valid && !in_stall)
				pending_attacks.push_back(predict_attacks(cmd, square, occupancy));
			if (out_valid && !out_stall) begin
				if (pending_attacks.size() == 0) begin
					$error("attack_set: unexpected result %h with no request outstanding",
						attack_set);
					fail_count++;
				end else begin
					expected_set = pending_attacks.pop_front();
					if (attack_set !== expected_set) begin
						$error("attack_set: expected %h, actual %h", expected_set, attack_set);
						fail_count++;
					end
				end
			end
		end
	end

	// Watchdog: abort a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		// Hold reset, then release it on a clock edge.
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Phase one: sender mostly busy, receiver stalling often.
		send_idle_pct = 14;
		recv_stall_pct = 67;
		test_sliders();
		test_leapers();
		test_pawns();
		test_spare_codes();
		test_random_traffic(700);
		test_drain_pause();

		// Phase two: sender sparse, receiver mostly ready.
		send_idle_pct = 67;
		recv_stall_pct = 14;
		test_random_traffic(700);

		// Phase three: full rate on both sides.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random_traffic(600);

		// Let the tail drain, then watch a little longer for stray results.
		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending_attacks.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
